// File: rtl/core/rss_pkg.sv
// shared types and constants for the row selection sorter
// no dependencies; imported by rss_row_store and row_selection_sorter
package rss_pkg;

  localparam int VALUE_W = 16;
  localparam int POS_W   = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ_I,
    ST_FIRST,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/core/rss_row_store.sv
// row store: one write port, one read port with registered read data
// depends on rss_pkg for the element width
module rss_row_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [rss_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [rss_pkg::VALUE_W-1:0] rdata
);
  import rss_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/row_selection_sorter.sv
// row selection sorter top level: sequencer, shared comparator, output register
// depends on rss_pkg and rss_row_store
//
// usage:
//   s_axis carries one row element per item (tlast closes the row). a row
//   also closes on the element that fills the store to MAX_ROW entries.
//   m_axis returns the row sorted ascending (signed), one item per element,
//   with its position and tlast on the final item of the row.
// timing:
//   loading accepts one element per cycle while s_axis_tvalid is high, and
//   s_axis_tready is high only while the block is loading a row, so a new row
//   waits until the previous row is emitted. after the closing element, each
//   position i of the row takes one store read, a scan with the single
//   comparator reading one entry a cycle, and one emit, in that order.
// reset:
//   rst clears the sequencer, element count and output valid; the store is
//   left as is and only entries written in the current row are read.
// stalls:
//   a result waits in the output register; the sorter pauses at its emit
//   step until the register frees up, nothing is dropped.
module row_selection_sorter #(
  parameter int MAX_ROW = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] element_value
  input  logic                           s_axis_tlast,  // last_in_row
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] sorted_value, [18:16] position, [23:19] zero
  output logic [rss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast   // row_end
);
  import rss_pkg::*;

  localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int CW = $clog2(MAX_ROW + 1);

  state_t state, state_next;

  logic [CW-1:0]      count;
  logic [CW-1:0]      n;
  logic [AW-1:0]      i;
  logic [CW-1:0]      j;
  logic [AW-1:0]      best;
  logic [VALUE_W-1:0] min_val;
  logic [VALUE_W-1:0] ival;

  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]   out_pos;
  logic               out_last;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;

  logic               in_acc;
  logic [CW-1:0]      count_inc;
  logic               row_close;
  logic [CW-1:0]      j_inc;
  logic [CW-1:0]      i_inc;
  logic               out_free;
  logic               emit_go;
  logic               is_less;
  logic               last_pos;

  rss_row_store #(
    .DEPTH (MAX_ROW),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign s_axis_tready = (state == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign count_inc     = count + CW'(1);
  assign row_close     = s_axis_tlast || (count_inc == CW'(MAX_ROW));
  assign i_inc         = CW'(i) + CW'(1);
  assign j_inc         = j + CW'(1);
  assign last_pos      = (i_inc == n);
  assign out_free      = !out_valid || m_axis_tready;
  assign emit_go       = (state == ST_EMIT) && out_free;
  assign is_less       = $signed(rdata) < $signed(min_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = best;
    wdata      = ival;
    raddr      = i;
    case (state)
      ST_LOAD: begin
        waddr = count[AW-1:0];
        wdata = s_axis_tdata[VALUE_W-1:0];
        if (in_acc) begin
          we = 1'b1;
          if (row_close) begin
            state_next = ST_READ_I;
          end
        end
      end
      ST_READ_I: begin
        raddr      = i;
        state_next = ST_FIRST;
      end
      ST_FIRST: begin
        raddr = i_inc[AW-1:0];
        if (last_pos) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        raddr = j_inc[AW-1:0];
        if (j_inc == n) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // move the old entry at i into the slot the minimum came from
        we = (best != i);
        if (out_free) begin
          state_next = last_pos ? ST_LOAD : ST_READ_I;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc) begin
      count <= row_close ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        if (in_acc && row_close) begin
          n <= count_inc;
          i <= '0;
        end
      end
      ST_FIRST: begin
        ival    <= rdata;
        min_val <= rdata;
        best    <= i;
        j       <= i_inc;
      end
      ST_SCAN: begin
        if (is_less) begin
          min_val <= rdata;
          best    <= j[AW-1:0];
        end
        j <= j_inc;
      end
      ST_EMIT: begin
        if (out_free && !last_pos) begin
          i <= i + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_value <= min_val;
      out_pos   <= POS_W'(i);
      out_last  <= last_pos;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - VALUE_W - POS_W){1'b0}}, out_pos, out_value};
  assign m_axis_tlast  = out_last;

  // open row never holds a full store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (count < CW'(MAX_ROW)))
    else $error("element count reached store depth while loading");

  // running minimum always comes from the unsorted part already scanned
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ((best >= i) && (CW'(best) < j) && (j < n)))
    else $error("scan index or minimum index out of range");

  // a sorted position is always inside the closed row
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (i_inc <= n))
    else $error("emit position beyond row length");

  // the last result of a row returns the sequencer to loading
  a_last_to_load: assert property (@(posedge clk) disable iff (rst)
    (emit_go && last_pos) |=> (state == ST_LOAD) && m_axis_tvalid && m_axis_tlast)
    else $error("row end did not return to loading");

endmodule

// File: tb/sv/row_selection_sorter_tb.sv
// testbench for row_selection_sorter: directed and random rows, each result checked
// against a selection-sort predictor kept in the bench; depends on rss_pkg and the rtl
`timescale 1ns / 100ps

module row_selection_sorter_tb;
  import rss_pkg::*;

  localparam int ROW_CAP      = 8;
  localparam int RANDOM_ITEMS = 50;
  localparam int STEADY_ITEMS = 25;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t           value;
    logic [POS_W-1:0] pos;
    logic             row_end;
  } sorted_item_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  value_t       open_row[$];
  sorted_item_t sorted_expected[$];

  int  error_count   = 0;
  int  elements_sent = 0;
  int  rows_closed   = 0;
  int  results_seen  = 0;
  bit  steady        = 1'b0;
  bit  hold_req      = 1'b0;

  row_selection_sorter #(
    .MAX_ROW(ROW_CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // row bookkeeping; a closed row is sorted and queued as expected items
  function automatic void record_element(value_t v, logic last);
    int     n, i, j, best;
    value_t t;
    sorted_item_t item;
    open_row.push_back(v);
    if (!last && open_row.size() < ROW_CAP) return;
    n = open_row.size();
    for (i = 0; i < n; i++) begin
      best = i;
      for (j = i + 1; j < n; j++) begin
        if (open_row[j] < open_row[best]) best = j;
      end
      t              = open_row[i];
      open_row[i]    = open_row[best];
      open_row[best] = t;
    end
    for (i = 0; i < n; i++) begin
      item.value   = open_row[i];
      item.pos     = POS_W'(i);
      item.row_end = (i == n - 1);
      sorted_expected.push_back(item);
    end
    open_row.delete();
    rows_closed++;
  endfunction

  // entered and left at a falling edge
  task automatic send_element(input value_t v, input logic last);
    while (!steady && $urandom_range(99) < 30) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = v;
    s_axis_tlast  = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    record_element(v, last);
    elements_sent++;
    @(negedge clk);
  endtask

  task automatic send_row(input value_t vals[$], input logic last_flag);
    int k;
    for (k = 0; k < vals.size(); k++)
      send_element(vals[k], (k == vals.size() - 1) ? last_flag : 1'b0);
  endtask

  // output side: random stalls, plus a long hold-off on request
  initial begin : output_sink
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else if (steady) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin : result_check
    sorted_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (sorted_expected.size() == 0) begin
        $error("unexpected result: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = sorted_expected.pop_front();
        if ($signed(m_axis_tdata[VALUE_W-1:0]) != want.value) begin
          $error("sorted_value: expected %0d, actual %0d", want.value,
                 $signed(m_axis_tdata[VALUE_W-1:0]));
          error_count++;
        end
        if (m_axis_tdata[VALUE_W+POS_W-1:VALUE_W] != want.pos) begin
          $error("position: expected %0d, actual %0d", want.pos,
                 m_axis_tdata[VALUE_W+POS_W-1:VALUE_W]);
          error_count++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:VALUE_W+POS_W] != '0) begin
          $error("tdata pad: expected 0, actual %0h",
                 m_axis_tdata[OUT_TDATA_W-1:VALUE_W+POS_W]);
          error_count++;
        end
        if (m_axis_tlast != want.row_end) begin
          $error("row_end: expected %0b, actual %0b", want.row_end, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  task automatic test_single_element_rows();
    send_element(16'sh7FFF, 1'b1);
    send_element(16'sh8000, 1'b1);
    send_element(16'sh0000, 1'b1);
  endtask

  task automatic test_extreme_values();
    send_row('{16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0000}, 1'b1);
  endtask

  // store full closes the row with tlast low
  task automatic test_full_row_no_last();
    send_row('{16'sd700, 16'sd500, 16'sd300, 16'sd100, -16'sd100, -16'sd300,
               -16'sd500, -16'sd700}, 1'b0);
  endtask

  task automatic test_full_row_with_last();
    send_row('{16'sd3, 16'sh8000, 16'sd1, 16'sh7FFF, 16'sd0, -16'sd2, 16'sd2,
               16'sh5555}, 1'b1);
  endtask

  task automatic test_equal_values();
    send_row('{16'sh2AAA, 16'sh2AAA, -16'sd1, 16'sh2AAA}, 1'b1);
  endtask

  task automatic test_random_rows();
    int     sent, len, k, mode;
    value_t vals[$];
    logic   last;
    sent   = 0;
    steady = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      // a quiet stretch at the start, then random idling on both sides
      if (sent >= STEADY_ITEMS) steady = 1'b0;
      len  = $urandom_range(ROW_CAP, 1);
      mode = $urandom_range(3);
      vals.delete();
      for (k = 0; k < len; k++) begin
        case (mode)
          0: vals.push_back(VALUE_W'($urandom_range(6)) - 16'sd3);
          1: begin
            case ($urandom_range(3))
              0: vals.push_back(16'sh7FFF);
              1: vals.push_back(16'sh8000);
              2: vals.push_back(16'shFFFF);
              default: vals.push_back(16'sh0000);
            endcase
          end
          default: vals.push_back(VALUE_W'($urandom));
        endcase
      end
      last = (len == ROW_CAP) ? 1'($urandom_range(1)) : 1'b1;
      send_row(vals, last);
      sent += len;
    end
    steady = 1'b0;
  endtask

  // output held off long enough that the block fills and stalls its input
  task automatic test_output_backpressure();
    int     r, k;
    value_t vals[$];
    hold_req = 1'b1;
    for (r = 0; r < 3; r++) begin
      vals.delete();
      for (k = 0; k < ROW_CAP; k++) vals.push_back(VALUE_W'($urandom));
      send_row(vals, 1'b1);
    end
  endtask

  initial begin : run
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_element_rows();
    test_extreme_values();
    test_full_row_no_last();
    test_full_row_with_last();
    test_equal_values();
    test_random_rows();
    test_output_backpressure();

    s_axis_tvalid = 1'b0;
    while (sorted_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d elements in %0d rows, checked %0d sorted items", elements_sent,
             rows_closed, results_seen);
    $display("rows of 1 to %0d, store-full closes, duplicates, a %0d-cycle output hold",
             ROW_CAP, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/rss_pkg.sv
rtl/core/rss_row_store.sv
rtl/core/row_selection_sorter.sv
tb/sv/row_selection_sorter_tb.sv
